### src/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg: shared types, constants and tables for the softmax block.
// Holds the element and result widths, the exponent table and the
// controller state type.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_W          = 16;
    localparam int PROB_W           = 16;
    localparam int EXP_W            = 17;
    localparam int EXP_BITS         = 12;
    localparam int SUM_W            = 28;
    localparam int QUO_W            = 34;

    // Controller states.
    typedef enum logic [2:0] {
        t_st_load  = 3'd0,
        t_st_exp   = 3'd1,
        t_st_div   = 3'd2,
        t_st_emit  = 3'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store the incoming element
        logic exp_start;  // start the exponent of the element at the index
        logic exp_step;   // one multiply step of the exponent
        logic exp_write;  // write back the exponent and add it to the total
        logic div_start;  // start the division of the element at the index
        logic div_step;   // one quotient bit
        logic emit;       // load the quotient into the output register
        logic clear;      // clear vector state after the last result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_done;
        logic div_done;
    } t_status;

    // exp(-2^k/256) in Q0.30.
    function automatic logic [29:0] exp_tab(input logic [3:0] k);
        logic [29:0] v;
        unique case (k)
            4'd0:    v = 30'd1069555701;
            4'd1:    v = 30'd1065385899;
            4'd2:    v = 30'd1057095000;
            4'd3:    v = 30'd1040706261;
            4'd4:    v = 30'd1008687096;
            4'd5:    v = 30'd947573834;
            4'd6:    v = 30'd836230973;
            4'd7:    v = 30'd651257337;
            4'd8:    v = 30'd395007542;
            4'd9:    v = 30'd145315154;
            4'd10:   v = 30'd19666268;
            4'd11:   v = 30'd360200;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

### src/smx_stream_if.sv
// ----------------------------------------------------------------------------
// smx_in_if / smx_out_if: valid/ready channels of the softmax block.
// A transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface smx_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] value;
    logic              last_in_vector;
    modport source (output valid, output value, output last_in_vector, input ready);
    modport sink   (input valid, input value, input last_in_vector, output ready);
endinterface

interface smx_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] probability;
    logic        last_out;
    logic        overflow_error;
    modport source (output valid, output probability, output last_out,
                    output overflow_error, input ready);
    modport sink   (input valid, input probability, input last_out,
                    input overflow_error, output ready);
endinterface

### src/smx_ctrl.sv
// ----------------------------------------------------------------------------
// smx_ctrl: controller of the softmax block.
// Sequences loading, the exponent pass and the division pass over the
// element buffer, and hands each result to the output register.
// ----------------------------------------------------------------------------
module smx_ctrl #(
    parameter int MAX_ELEMENTS = smx_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    input  logic                i_out_ready,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0] i_count,
    input  smx_pkg::t_status    i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic                o_out_last,
    output logic [$clog2(MAX_ELEMENTS)-1:0] o_index,
    output smx_pkg::t_cmd       o_cmd
);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);

    smx_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_busy, n_busy;   // a unit step is under way
    logic            r_ovalid, n_ovalid;
    logic            r_olast, n_olast;
    logic            in_xfer, out_free, last_idx;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign last_idx = (r_idx + CW'(1)) == i_count;

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_busy   = r_busy;
        n_ovalid = r_ovalid && !i_out_ready;
        n_olast  = r_olast;
        unique case (r_state)
            smx_pkg::t_st_load: begin
                if (in_xfer && i_in_last) begin
                    n_state = smx_pkg::t_st_exp;
                    n_idx   = '0;
                    n_busy  = 1'b0;
                end
            end
            smx_pkg::t_st_exp: begin
                if (!r_busy) begin
                    n_busy = 1'b1;
                end else if (i_status.exp_done) begin
                    n_busy = 1'b0;
                    if (last_idx) begin
                        n_state = smx_pkg::t_st_div;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            smx_pkg::t_st_div: begin
                if (!r_busy) begin
                    n_busy = 1'b1;
                end else if (i_status.div_done) begin
                    n_busy  = 1'b0;
                    n_state = smx_pkg::t_st_emit;
                end
            end
            smx_pkg::t_st_emit: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olast  = last_idx;
                    if (last_idx) begin
                        n_state = smx_pkg::t_st_load;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = smx_pkg::t_st_div;
                    end
                end
            end
            default: n_state = smx_pkg::t_st_load;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == smx_pkg::t_st_load);
        unique case (r_state)
            smx_pkg::t_st_load: o_cmd.load = in_xfer;
            smx_pkg::t_st_exp: begin
                o_cmd.exp_start = !r_busy;
                o_cmd.exp_step  = r_busy && !i_status.exp_done;
                o_cmd.exp_write = r_busy && i_status.exp_done;
            end
            smx_pkg::t_st_div: begin
                o_cmd.div_start = !r_busy;
                o_cmd.div_step  = r_busy && !i_status.div_done;
            end
            smx_pkg::t_st_emit: begin
                o_cmd.emit  = out_free;
                o_cmd.clear = out_free && last_idx;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_last  = r_olast;
    assign o_index     = r_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= smx_pkg::t_st_load;
            r_idx    <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            r_olast  <= n_olast;
        end
    end

endmodule

### src/smx_datapath.sv
// ----------------------------------------------------------------------------
// smx_datapath: element buffer, running maximum, exponent unit, sum and
// restoring divider of the softmax block. It acts only on controller
// commands.
// ----------------------------------------------------------------------------
module smx_datapath #(
    parameter int MAX_ELEMENTS = smx_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smx_pkg::t_cmd         i_cmd,
    input  logic [$clog2(MAX_ELEMENTS)-1:0] i_index,
    input  logic signed [15:0]    i_value,
    input  logic                  i_out_take,
    output logic [$clog2(MAX_ELEMENTS+1)-1:0] o_count,
    output smx_pkg::t_status      o_status,
    output logic [15:0]           o_probability,
    output logic                  o_overflow
);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int SW = smx_pkg::EXP_W + CW;   // sum width

    // Element buffer: raw element, later its exponent.
    logic [smx_pkg::EXP_W-1:0] r_mem [MAX_ELEMENTS];
    logic [smx_pkg::EXP_W-1:0] r_rd;

    logic signed [15:0] r_max;
    logic [CW-1:0]      r_count;
    logic [SW-1:0]      r_sum;
    logic               r_drop;

    // Exponent unit.
    logic [3:0]  r_k;
    logic [16:0] r_m;        // distance, sign-extended; bits 16:12 flag >= 16.0
    logic [31:0] r_r;        // Q2.30 accumulator
    logic        r_ephase;   // 0: read data pending
    logic [61:0] prod;
    logic [31:0] r_next;
    logic [16:0] e_val;
    logic signed [16:0] gap;

    // Divider.
    logic [SW+16:0] r_rem;
    logic [16:0]    r_q;
    logic [5:0]     r_dcnt;
    logic           r_dphase;

    assign o_count = r_count;

    // Buffer write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CW'(MAX_ELEMENTS))) begin
            r_mem[r_count[IW-1:0]] <= {1'b0, i_value};
        end else if (i_cmd.exp_write) begin
            r_mem[i_index] <= e_val;
        end
        r_rd <= r_mem[i_index];
    end

    // Vector state: count, maximum, drop flag and sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_max   <= 16'sh8000;
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_count < CW'(MAX_ELEMENTS)) begin
                    r_count <= r_count + CW'(1);
                    if (i_value > r_max) r_max <= i_value;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.exp_write) r_sum <= r_sum + SW'(e_val);
        end
    end

    // One table multiply per set bit of distance bits 11:0, one bit per cycle.
    assign gap   = 17'(r_max) - 17'($signed(r_rd[15:0]));
    assign prod  = r_r[31:0] * 62'(smx_pkg::exp_tab(r_k));
    assign r_next = 32'((prod + 62'(1 << 29)) >> 30);
    assign e_val = (r_m[16:12] != 5'd0) ? 17'd0 : 17'((r_r + 32'd8192) >> 14);
    assign o_status.exp_done = r_ephase && (r_k == 4'(smx_pkg::EXP_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ephase <= 1'b0;
            r_k      <= '0;
        end else if (i_cmd.exp_start) begin
            r_ephase <= 1'b0;
            r_k      <= '0;
        end else if (i_cmd.exp_step) begin
            if (!r_ephase) begin
                r_ephase <= 1'b1;
                r_m      <= gap;
                r_r      <= 32'd1 << 30;
            end else begin
                if (r_m[r_k]) r_r <= r_next;
                r_k <= r_k + 4'd1;
            end
        end
    end

    // Restoring division: (e*65536 + sum/2) / sum, one quotient bit a cycle.
    assign o_status.div_done = r_dphase && (r_dcnt == 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dphase <= 1'b0;
            r_dcnt   <= '0;
        end else if (i_cmd.div_start) begin
            r_dphase <= 1'b0;
        end else if (i_cmd.div_step) begin
            if (!r_dphase) begin
                // Dividend below 2^34; quotient fits 17 bits since e <= sum.
                r_dphase <= 1'b1;
                r_dcnt   <= 6'd17;
                r_rem    <= (SW+17)'({r_rd, 16'd0}) + (SW+17)'(r_sum >> 1);
                r_q      <= '0;
            end else begin
                r_dcnt <= r_dcnt - 6'd1;
                r_q    <= {r_q[15:0],
                           (r_rem >> (r_dcnt - 6'd1)) >= (SW+17)'(r_sum)};
                if ((r_rem >> (r_dcnt - 6'd1)) >= (SW+17)'(r_sum))
                    r_rem <= r_rem - ((SW+17)'(r_sum) << (r_dcnt - 6'd1));
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_out_take) begin
            o_probability <= r_q[16] ? 16'hFFFF : r_q[15:0];
            o_overflow    <= r_drop;
        end
    end

endmodule

### src/softmax_vector.sv
// ----------------------------------------------------------------------------
// softmax_vector: softmax over one vector at a time.
// Elements (signed Q8.8) are loaded one per cycle while loading, one result
// is produced per stored element as unsigned Q0.16, saturated to 65535.
// ----------------------------------------------------------------------------
// Sequence: after the last element the exponent pass takes each element in
// turn (it fetches the element, forms its distance from the maximum, runs
// twelve table steps on one shared multiplier and writes back). The
// division pass then takes each element in turn (it fetches the exponent,
// sets up the dividend, forms seventeen quotient bits in a restoring
// divider, finishes and hands the result to the output register once the
// output is free); a stalled output holds the pass. Input is accepted only
// while loading. Elements beyond MAX_ELEMENTS are dropped and every result
// of that vector carries overflow_error.
module softmax_vector #(
    parameter int MAX_ELEMENTS = smx_pkg::MAX_ELEMENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smx_in_if.sink    in_ch,
    smx_out_if.source out_ch
);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);

    smx_pkg::t_cmd    cmd;
    smx_pkg::t_status status;
    logic [CW-1:0]    count;
    logic [IW-1:0]    index;
    logic             take;

    // A new result is loaded when the controller emits one.
    assign take = cmd.emit;

    smx_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_last   (in_ch.last_in_vector),
        .i_out_ready (out_ch.ready),
        .i_count     (count),
        .i_status    (status),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_out_last  (out_ch.last_out),
        .o_index     (index),
        .o_cmd       (cmd)
    );

    smx_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_index       (index),
        .i_value       (in_ch.value),
        .i_out_take    (take),
        .o_count       (count),
        .o_status      (status),
        .o_probability (out_ch.probability),
        .o_overflow    (out_ch.overflow_error)
    );

endmodule
